/* design/ctm_pkg.sv */
package ctm_pkg;

  // Full scale of the match score: a perfect fit with no bonus terms.
  localparam logic [18:0] FULL_SCALE   = 19'd420000;
  localparam logic [18:0] THRESH_RESET = 19'd126000;
  localparam logic [21:0] EXACT_BONUS  = 22'd84000;
  localparam logic [15:0] PRIO_WEIGHT  = 16'd420;
  localparam logic [19:0] EXTRA_COST   = 20'd42000;
  localparam logic [19:0] MISS_COST    = 20'd63000;
  localparam logic [3:0]  LAST_CLASS   = 4'd11;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_SINGLE  = 2'd1,
    ST_CHORD   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    logic [11:0] mask;
    logic [6:0]  prio;
  } tmpl_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } ctm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic trivial;
    logic last_issue;
    logic s1_busy;
  } ctm_stat_t;

  function automatic logic [3:0] popcount12(input logic [11:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 12; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  // Score of one matched interval for a template of the given size. Every
  // size that the template table holds divides full scale exactly.
  function automatic logic [18:0] unit_for_size(input logic [3:0] size);
    logic [18:0] u;
    unique case (size)
      4'd1:    u = 19'd420000;
      4'd2:    u = 19'd210000;
      4'd3:    u = 19'd140000;
      4'd4:    u = 19'd105000;
      4'd5:    u = 19'd84000;
      4'd6:    u = 19'd70000;
      4'd7:    u = 19'd60000;
      4'd8:    u = 19'd52500;
      4'd9:    u = 19'd46666;
      4'd10:   u = 19'd42000;
      4'd11:   u = 19'd38181;
      4'd12:   u = 19'd35000;
      default: u = 19'd0;
    endcase
    return u;
  endfunction

  // Remainder by twelve of a note number 0..127 via a reciprocal multiply.
  function automatic logic [3:0] mod12(input logic [6:0] v);
    logic [12:0] p;
    logic [7:0]  r;
    p = 13'(v) * 13'd43;
    r = 8'(v) - 8'(p[12:9]) * 8'd12;
    if (r >= 8'd12) begin
      r = r - 8'd12;
    end
    return r[3:0];
  endfunction

  function automatic logic flats_for(input logic [3:0] pc);
    logic f;
    unique case (pc)
      4'd1, 4'd3, 4'd6, 4'd8, 4'd10: f = 1'b1;
      default:                       f = 1'b0;
    endcase
    return f;
  endfunction

  // Interval templates; bit k of the mask is the interval of k semitones.
  function automatic tmpl_t tmpl_rom(input logic [5:0] idx);
    tmpl_t t;
    unique case (idx)
      6'd0:    t = '{mask: 12'h091, prio: 7'd110};
      6'd1:    t = '{mask: 12'h089, prio: 7'd110};
      6'd2:    t = '{mask: 12'h049, prio: 7'd105};
      6'd3:    t = '{mask: 12'h111, prio: 7'd105};
      6'd4:    t = '{mask: 12'h0A1, prio: 7'd100};
      6'd5:    t = '{mask: 12'h085, prio: 7'd100};
      6'd6:    t = '{mask: 12'h081, prio: 7'd95};
      6'd7:    t = '{mask: 12'h891, prio: 7'd90};
      6'd8:    t = '{mask: 12'h489, prio: 7'd90};
      6'd9:    t = '{mask: 12'h491, prio: 7'd92};
      6'd10:   t = '{mask: 12'h249, prio: 7'd88};
      6'd11:   t = '{mask: 12'h449, prio: 7'd88};
      6'd12:   t = '{mask: 12'h889, prio: 7'd85};
      6'd13:   t = '{mask: 12'h911, prio: 7'd82};
      6'd14:   t = '{mask: 12'h511, prio: 7'd82};
      6'd15:   t = '{mask: 12'h4A1, prio: 7'd85};
      6'd16:   t = '{mask: 12'h485, prio: 7'd85};
      6'd17:   t = '{mask: 12'h291, prio: 7'd86};
      6'd18:   t = '{mask: 12'h289, prio: 7'd86};
      6'd19:   t = '{mask: 12'h295, prio: 7'd75};
      6'd20:   t = '{mask: 12'h895, prio: 7'd78};
      6'd21:   t = '{mask: 12'h48D, prio: 7'd78};
      6'd22:   t = '{mask: 12'h495, prio: 7'd80};
      6'd23:   t = '{mask: 12'h095, prio: 7'd75};
      6'd24:   t = '{mask: 12'h08D, prio: 7'd75};
      6'd25:   t = '{mask: 12'h493, prio: 7'd72};
      6'd26:   t = '{mask: 12'h499, prio: 7'd72};
      6'd27:   t = '{mask: 12'h8B5, prio: 7'd62};
      6'd28:   t = '{mask: 12'h4AD, prio: 7'd62};
      6'd29:   t = '{mask: 12'h4B5, prio: 7'd64};
      6'd30:   t = '{mask: 12'h4A5, prio: 7'd60};
      6'd31:   t = '{mask: 12'h0B1, prio: 7'd57};
      6'd32:   t = '{mask: 12'hAB5, prio: 7'd55};
      6'd33:   t = '{mask: 12'h6AD, prio: 7'd55};
      6'd34:   t = '{mask: 12'h695, prio: 7'd58};
      6'd35:   t = '{mask: 12'h451, prio: 7'd52};
      6'd36:   t = '{mask: 12'h851, prio: 7'd50};
      6'd37:   t = '{mask: 12'h4D1, prio: 7'd48};
      6'd38:   t = '{mask: 12'h4D5, prio: 7'd47};
      6'd39:   t = '{mask: 12'h693, prio: 7'd46};
      6'd40:   t = '{mask: 12'h45B, prio: 7'd40};
      6'd41:   t = '{mask: 12'h011, prio: 7'd30};
      6'd42:   t = '{mask: 12'h009, prio: 7'd30};
      6'd43:   t = '{mask: 12'h411, prio: 7'd35};
      6'd44:   t = '{mask: 12'h481, prio: 7'd35};
      6'd45:   t = '{mask: 12'h811, prio: 7'd35};
      6'd46:   t = '{mask: 12'h881, prio: 7'd35};
      6'd47:   t = '{mask: 12'h409, prio: 7'd35};
      6'd48:   t = '{mask: 12'h421, prio: 7'd25};
      default: t = '{mask: 12'h000, prio: 7'd0};
    endcase
    return t;
  endfunction

endpackage

/* design/ctm_channels.sv */
interface ctm_in_if;
  logic              valid;
  logic              ready;
  logic [11:0]       pitch_set;
  logic signed [7:0] lowest_note;

  modport source (output valid, output pitch_set, output lowest_note, input ready);
  modport sink (input valid, input pitch_set, input lowest_note, output ready);
endinterface

interface ctm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  root_class;
  logic [3:0]  bass_class;
  logic [5:0]  chord_index;
  logic [18:0] match_score;
  logic        is_inversion;
  logic        use_flats;

  modport source (
    output valid, output status, output root_class, output bass_class,
    output chord_index, output match_score, output is_inversion, output use_flats,
    input ready
  );
  modport sink (
    input valid, input status, input root_class, input bass_class,
    input chord_index, input match_score, input is_inversion, input use_flats,
    output ready
  );
endinterface

/* design/chord_template_matcher.sv */
// Channel  Dir  Payload                                              Handshake
// notes    in   pitch_set[11:0], lowest_note[7:0] (signed)           valid/ready
// chord    out  status, root_class, bass_class, chord_index,         valid/ready
//               match_score, is_inversion, use_flats
// cfg      in   cfg_wr_data[18:0] (accept threshold)                 cfg_wr_en
//
// A word with two or more pitch classes is scored against every root and template
// pair: the scorer tries one root and template pair per cycle, through its two
// pipeline stages. An empty or single-note word issues no pairs.
// Reset is synchronous; it restores the threshold to 126000 and empties the block.
// A new word is accepted as soon as the previous result sits in the output
// register, even if the consumer has not taken it yet; a stalled result is held.
module chord_template_matcher #(
  parameter int NUM_TEMPLATES = 50
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [18:0]  cfg_wr_data,
  ctm_in_if.sink       notes,
  ctm_out_if.source    chord
);

  // Control and status between the sequencer and the scoring datapath.
  ctm_pkg::ctm_cmd_t  cmd;
  ctm_pkg::ctm_stat_t stat;

  // The controller walks idle, scan and drain states. During the scan it issues
  // one root/template pair per cycle; the drain state waits for the scorer
  // pipeline to empty and for room in the output register.
  ctm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (notes.valid),
    .in_ready  (notes.ready),
    .out_valid (chord.valid),
    .out_ready (chord.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the captured word, the root and template counters, the
  // two-stage scorer, the running best and the output payload register. Ties keep
  // the earlier candidate because only a strictly higher score replaces the best.
  ctm_datapath #(
    .NUM_TEMPLATES (NUM_TEMPLATES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .pitch_set    (notes.pitch_set),
    .lowest_note  (notes.lowest_note),
    .cmd          (cmd),
    .stat         (stat),
    .status       (chord.status),
    .root_class   (chord.root_class),
    .bass_class   (chord.bass_class),
    .chord_index  (chord.chord_index),
    .match_score  (chord.match_score),
    .is_inversion (chord.is_inversion),
    .use_flats    (chord.use_flats)
  );

endmodule

/* design/ctm_ctrl.sv */
module ctm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ctm_pkg::ctm_stat_t  stat,
  output ctm_pkg::ctm_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready   = (state == S_IDLE);
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.issue  = (state == S_SCAN) && !stat.trivial;
    cmd.finish = (state == S_DRAIN) && !stat.s1_busy && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.trivial || stat.last_issue) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (cmd.finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/ctm_datapath.sv */
module ctm_datapath #(
  parameter int NUM_TEMPLATES = 50
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [18:0]        cfg_wr_data,
  input  logic [11:0]        pitch_set,
  input  logic signed [7:0]  lowest_note,
  input  ctm_pkg::ctm_cmd_t  cmd,
  output ctm_pkg::ctm_stat_t stat,
  output logic [1:0]         status,
  output logic [3:0]         root_class,
  output logic [3:0]         bass_class,
  output logic [5:0]         chord_index,
  output logic [18:0]        match_score,
  output logic               is_inversion,
  output logic               use_flats
);

  localparam int TW = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
  localparam logic [TW-1:0] TMPL_LAST = TW'(NUM_TEMPLATES - 1);

  logic [18:0]       thresh;
  logic [11:0]       set_r;
  logic signed [7:0] note_r;
  logic [3:0]        root;
  logic [TW-1:0]     tmpl;

  // Scoring stage one.
  logic              s1_valid;
  logic              s1_zero;
  logic              s1_exact;
  logic [18:0]       s1_frac;
  logic [15:0]       s1_prio;
  logic [19:0]       s1_pen;
  logic [3:0]        s1_root;
  logic [TW-1:0]     s1_tmpl;

  logic [18:0]       best;
  logic [3:0]        best_root;
  logic [TW-1:0]     best_tmpl;

  // Stage zero: rotate the set to the current root and count against the template.
  logic [23:0]        set_dbl;
  logic [11:0]        rot;
  ctm_pkg::tmpl_t     entry;
  logic [3:0]         size;
  logic [3:0]         hit_cnt;
  logic [3:0]         missing;
  logic [3:0]         extra;
  logic [22:0]        frac_prod;

  always_comb begin
    set_dbl   = {set_r, set_r};
    rot       = 12'(set_dbl >> root);
    entry     = ctm_pkg::tmpl_rom(6'(tmpl));
    size      = ctm_pkg::popcount12(entry.mask);
    hit_cnt   = ctm_pkg::popcount12(rot & entry.mask);
    missing   = ctm_pkg::popcount12(entry.mask & ~rot);
    extra     = ctm_pkg::popcount12(rot & ~entry.mask);
    frac_prod = 23'(hit_cnt) * 23'(ctm_pkg::unit_for_size(size));
  end

  // Stage two: sum, clamp and compare against the running best.
  logic signed [21:0] sum;
  logic [18:0]        score;
  logic               better;

  always_comb begin
    sum = $signed({3'b000, s1_frac}) + $signed({6'b000000, s1_prio})
        + $signed(s1_exact ? ctm_pkg::EXACT_BONUS : 22'd0)
        - $signed({2'b00, s1_pen});
    if (s1_zero || sum < 22'sd0) begin
      score = 19'd0;
    end else if (sum > $signed({3'b000, ctm_pkg::FULL_SCALE})) begin
      score = ctm_pkg::FULL_SCALE;
    end else begin
      score = sum[18:0];
    end
    better = s1_valid && (score > best);
  end

  // Result composition.
  logic       known;
  logic [3:0] low_pc;
  logic [3:0] count;
  logic [3:0] first_pc;
  logic [3:0] single_pc;
  logic [3:0] chord_bass;

  always_comb begin
    known    = !note_r[7];
    low_pc   = ctm_pkg::mod12(note_r[6:0]);
    count    = ctm_pkg::popcount12(set_r);
    first_pc = 4'd0;
    for (int i = 11; i >= 0; i--) begin
      if (set_r[i]) first_pc = 4'(i);
    end
    single_pc  = known ? low_pc : first_pc;
    chord_bass = known ? low_pc : best_root;
  end

  always_comb begin
    stat.trivial    = (count < 4'd2);
    stat.last_issue = (root == ctm_pkg::LAST_CLASS) && (tmpl == TMPL_LAST);
    stat.s1_busy    = s1_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh   <= ctm_pkg::THRESH_RESET;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) thresh <= cfg_wr_data;
      s1_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r  <= pitch_set;
      note_r <= lowest_note;
      root   <= 4'd0;
      tmpl   <= '0;
    end else if (cmd.issue) begin
      if (tmpl == TMPL_LAST) begin
        tmpl <= '0;
        root <= root + 4'd1;
      end else begin
        tmpl <= tmpl + TW'(1);
      end
    end

    if (cmd.issue) begin
      s1_zero  <= (size == 4'd0) || !rot[0];
      s1_exact <= (missing == 4'd0) && (extra == 4'd0);
      s1_frac  <= frac_prod[18:0];
      s1_prio  <= 16'(entry.prio) * ctm_pkg::PRIO_WEIGHT;
      s1_pen   <= 20'(extra) * ctm_pkg::EXTRA_COST + 20'(missing) * ctm_pkg::MISS_COST;
      s1_root  <= root;
      s1_tmpl  <= tmpl;
    end

    if (cmd.load) begin
      best      <= 19'd0;
      best_root <= 4'd0;
      best_tmpl <= '0;
    end else if (better) begin
      best      <= score;
      best_root <= s1_root;
      best_tmpl <= s1_tmpl;
    end

    if (cmd.finish) begin
      if (count == 4'd1) begin
        status       <= ctm_pkg::ST_SINGLE;
        root_class   <= single_pc;
        bass_class   <= single_pc;
        chord_index  <= 6'd0;
        match_score  <= ctm_pkg::FULL_SCALE;
        is_inversion <= 1'b0;
        use_flats    <= ctm_pkg::flats_for(single_pc);
      end else if (count != 4'd0 && best != 19'd0 && best >= thresh) begin
        status       <= ctm_pkg::ST_CHORD;
        root_class   <= best_root;
        bass_class   <= chord_bass;
        chord_index  <= 6'(best_tmpl);
        match_score  <= best;
        is_inversion <= (chord_bass != best_root) && set_r[chord_bass];
        use_flats    <= ctm_pkg::flats_for(best_root);
      end else begin
        // No notes, or a best score of zero or below the threshold: every other field is zero.
        status       <= (count == 4'd0) ? ctm_pkg::ST_EMPTY : ctm_pkg::ST_UNKNOWN;
        root_class   <= 4'd0;
        bass_class   <= 4'd0;
        chord_index  <= 6'd0;
        match_score  <= 19'd0;
        is_inversion <= 1'b0;
        use_flats    <= 1'b0;
      end
    end
  end

endmodule

/* design/ctm_checker.sv */
module ctm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [3:0]  root_class,
  input logic [3:0]  bass_class,
  input logic [5:0]  chord_index,
  input logic [18:0] match_score,
  input logic        is_inversion,
  input logic        use_flats
);

  // One word at a time: the input closes right after an acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after acceptance");

  // A fresh result only appears at the end of processing, never from idle.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a word in flight");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(root_class)
      && $stable(bass_class) && $stable(chord_index) && $stable(match_score)
      && $stable(is_inversion) && $stable(use_flats))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ctm_pkg::ST_EMPTY |-> root_class == 4'd0
      && bass_class == 4'd0 && chord_index == 6'd0 && match_score == 19'd0
      && !is_inversion && !use_flats)
    else $error("empty result carries data");

  a_single_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ctm_pkg::ST_SINGLE |-> match_score == ctm_pkg::FULL_SCALE
      && root_class == bass_class && chord_index == 6'd0 && !is_inversion)
    else $error("single-note result malformed");

endmodule

bind chord_template_matcher ctm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (notes.valid),
  .in_ready     (notes.ready),
  .out_valid    (chord.valid),
  .out_ready    (chord.ready),
  .status       (chord.status),
  .root_class   (chord.root_class),
  .bass_class   (chord.bass_class),
  .chord_index  (chord.chord_index),
  .match_score  (chord.match_score),
  .is_inversion (chord.is_inversion),
  .use_flats    (chord.use_flats)
);

/* test/tb_chord_template_matcher.sv */
`timescale 1ns / 100ps

// Testbench for the chord template matcher.
//
// Words of notes go in on the notes channel and one chord word comes back for
// each. A word of notes with no expected word of its own is named by a
// predictor in this file, which keeps its own copy of the interval templates
// and of the accept threshold. Each expected word is queued, and each chord
// word from the block is checked field by field against the oldest in the queue.
//
// The run starts with a short table of directed words. Where the answer is
// obvious (empty set, single note, exact triad, threshold above full scale)
// the row carries the expected word itself. Every other row is checked against
// the predictor. Several random phases follow, each at its own threshold.
// Both sides of the handshake idle at random, first one pattern and then the
// other, and at the end neither side idles.
module tb_chord_template_matcher;

  localparam int TEMPLATE_COUNT = 50;
  // Tail wait: long enough for one full chord search plus margin.
  localparam int TAIL_CYCLES    = 700;
  localparam int DIRECTED_ROWS  = 24;
  localparam int PHASES         = 6;
  // Pitch classes that are spelled with flats when they are the root.
  localparam logic [11:0] FLAT_ROOTS = 12'h54A;

  typedef struct packed {
    ctm_pkg::status_t status;
    logic [3:0]       root;
    logic [3:0]       bass;
    logic [5:0]       idx;
    logic [18:0]      score;
    logic             inv;
    logic             flats;
  } chord_res_t;

  typedef struct packed {
    logic [11:0] iv;
    logic [7:0]  prio;
  } chord_shape_t;

  // One row of the directed table. When set_thr is high the threshold is
  // rewritten before the word goes out. When typed is high, want holds the
  // expected word; otherwise the predictor supplies it.
  typedef struct packed {
    logic [11:0] ps;
    logic [7:0]  ln;
    logic        set_thr;
    logic [18:0] thr;
    logic        typed;
    chord_res_t  want;
  } stim_row_t;

  localparam chord_res_t NONE = '0;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [18:0] cfg_wr_data;

  ctm_in_if  notes_ch ();
  ctm_out_if chord_ch ();

  chord_template_matcher #(
    .NUM_TEMPLATES(TEMPLATE_COUNT)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .notes      (notes_ch),
    .chord      (chord_ch)
  );

  // Chord words still owed by the block, oldest first.
  chord_res_t  pending_chords [$];
  logic [18:0] cur_thr = ctm_pkg::THRESH_RESET;
  int          errors = 0;
  int          chords_seen = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  // Cycles for which the chord sink must keep ready low.
  int          sink_hold = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The interval table, one entry per template. Bit k of iv is an interval of
  // k semitones above the root. Entries past the end of the table are empty.
  function automatic chord_shape_t interval_template(input int t);
    chord_shape_t s;
    case (t)
      0:  s = '{iv: 12'h091, prio: 8'd110};
      1:  s = '{iv: 12'h089, prio: 8'd110};
      2:  s = '{iv: 12'h049, prio: 8'd105};
      3:  s = '{iv: 12'h111, prio: 8'd105};
      4:  s = '{iv: 12'h0A1, prio: 8'd100};
      5:  s = '{iv: 12'h085, prio: 8'd100};
      6:  s = '{iv: 12'h081, prio: 8'd95};
      7:  s = '{iv: 12'h891, prio: 8'd90};
      8:  s = '{iv: 12'h489, prio: 8'd90};
      9:  s = '{iv: 12'h491, prio: 8'd92};
      10: s = '{iv: 12'h249, prio: 8'd88};
      11: s = '{iv: 12'h449, prio: 8'd88};
      12: s = '{iv: 12'h889, prio: 8'd85};
      13: s = '{iv: 12'h911, prio: 8'd82};
      14: s = '{iv: 12'h511, prio: 8'd82};
      15: s = '{iv: 12'h4A1, prio: 8'd85};
      16: s = '{iv: 12'h485, prio: 8'd85};
      17: s = '{iv: 12'h291, prio: 8'd86};
      18: s = '{iv: 12'h289, prio: 8'd86};
      19: s = '{iv: 12'h295, prio: 8'd75};
      20: s = '{iv: 12'h895, prio: 8'd78};
      21: s = '{iv: 12'h48D, prio: 8'd78};
      22: s = '{iv: 12'h495, prio: 8'd80};
      23: s = '{iv: 12'h095, prio: 8'd75};
      24: s = '{iv: 12'h08D, prio: 8'd75};
      25: s = '{iv: 12'h493, prio: 8'd72};
      26: s = '{iv: 12'h499, prio: 8'd72};
      27: s = '{iv: 12'h8B5, prio: 8'd62};
      28: s = '{iv: 12'h4AD, prio: 8'd62};
      29: s = '{iv: 12'h4B5, prio: 8'd64};
      30: s = '{iv: 12'h4A5, prio: 8'd60};
      31: s = '{iv: 12'h0B1, prio: 8'd57};
      32: s = '{iv: 12'hAB5, prio: 8'd55};
      33: s = '{iv: 12'h6AD, prio: 8'd55};
      34: s = '{iv: 12'h695, prio: 8'd58};
      35: s = '{iv: 12'h451, prio: 8'd52};
      36: s = '{iv: 12'h851, prio: 8'd50};
      37: s = '{iv: 12'h4D1, prio: 8'd48};
      38: s = '{iv: 12'h4D5, prio: 8'd47};
      39: s = '{iv: 12'h693, prio: 8'd46};
      40: s = '{iv: 12'h45B, prio: 8'd40};
      41: s = '{iv: 12'h011, prio: 8'd30};
      42: s = '{iv: 12'h009, prio: 8'd30};
      43: s = '{iv: 12'h411, prio: 8'd35};
      44: s = '{iv: 12'h481, prio: 8'd35};
      45: s = '{iv: 12'h811, prio: 8'd35};
      46: s = '{iv: 12'h881, prio: 8'd35};
      47: s = '{iv: 12'h409, prio: 8'd35};
      48: s = '{iv: 12'h421, prio: 8'd25};
      default: s = '{iv: 12'h000, prio: 8'd0};
    endcase
    return s;
  endfunction

  // Fit of a rotated set (root at bit 0) against one template, in units of
  // 1/420000, clamped to the range 0 to full scale. An empty template, or a
  // set without its root, scores nothing.
  function automatic int template_fit(input logic [11:0] rot, input int t);
    chord_shape_t sh;
    int size, hit, miss, extra, s;
    sh = interval_template(t);
    size = $countones(sh.iv);
    if (size == 0 || rot == 12'h000 || !rot[0]) return 0;
    hit   = $countones(rot & sh.iv);
    miss  = $countones(sh.iv & ~rot);
    extra = $countones(rot & ~sh.iv);
    s = hit * int'(ctm_pkg::FULL_SCALE) / size - 42000 * extra - 63000 * miss;
    // A set that is exactly the template earns a bonus.
    if (miss == 0 && extra == 0) s += 84000;
    s += 420 * int'(sh.prio);
    if (s < 0) s = 0;
    if (s > int'(ctm_pkg::FULL_SCALE)) s = int'(ctm_pkg::FULL_SCALE);
    return s;
  endfunction

  // Expected chord word for one word of notes at the given threshold.
  function automatic chord_res_t name_chord(input logic [11:0] ps, input logic [7:0] ln,
                                            input logic [18:0] thr);
    chord_res_t  r;
    logic        known;
    logic [11:0] rot;
    int          low_pc, pc, best, best_root, best_t, s, bass;
    r = NONE;
    // Any note number with the top bit set counts as unknown.
    known = !ln[7];
    low_pc = int'(ln[6:0]) % 12;
    if (ps == 12'h000) return r;
    if ($countones(ps) == 1) begin
      pc = 0;
      for (int i = 0; i < 12; i++) begin
        if (ps[i]) pc = i;
      end
      // A known lowest note names the note even when its class is not in the set.
      if (known) pc = low_pc;
      r.status = ctm_pkg::ST_SINGLE;
      r.root   = 4'(pc);
      r.bass   = 4'(pc);
      r.score  = ctm_pkg::FULL_SCALE;
      r.flats  = FLAT_ROOTS[pc];
      return r;
    end
    best = 0;
    best_root = 0;
    best_t = 0;
    for (int root = 0; root < 12; root++) begin
      if (ps[root]) begin
        for (int k = 0; k < 12; k++) begin
          rot[k] = ps[(root + k) % 12];
        end
        // Strictly greater: the lowest root and earliest template keep ties.
        for (int t = 0; t < TEMPLATE_COUNT; t++) begin
          s = template_fit(rot, t);
          if (s > best) begin
            best = s;
            best_root = root;
            best_t = t;
          end
        end
      end
    end
    if (best == 0 || best < int'(thr)) begin
      r.status = ctm_pkg::ST_UNKNOWN;
      return r;
    end
    bass = known ? low_pc : best_root;
    r.status = ctm_pkg::ST_CHORD;
    r.root   = 4'(best_root);
    r.bass   = 4'(bass);
    r.idx    = 6'(best_t);
    r.score  = 19'(best);
    r.inv    = (bass != best_root) && ps[bass];
    r.flats  = FLAT_ROOTS[best_root];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("chord word %0d: %s is %0d, expected %0d", chords_seen, what, got, want);
    errors++;
  endtask

  // Compares one chord word taken from the block with the oldest expectation.
  task automatic compare_chord(input chord_res_t got);
    chord_res_t want;
    chords_seen++;
    if (pending_chords.size() == 0) begin
      flag_mismatch("unexpected word, status", int'(got.status), -1);
      return;
    end
    want = pending_chords.pop_front();
    if (got.status != want.status) flag_mismatch("status", got.status, want.status);
    if (got.root != want.root) flag_mismatch("root_class", got.root, want.root);
    if (got.bass != want.bass) flag_mismatch("bass_class", got.bass, want.bass);
    if (got.idx != want.idx) flag_mismatch("chord_index", got.idx, want.idx);
    if (got.score != want.score) flag_mismatch("match_score", got.score, want.score);
    if (got.inv != want.inv) flag_mismatch("is_inversion", got.inv, want.inv);
    if (got.flats != want.flats) flag_mismatch("use_flats", got.flats, want.flats);
  endtask

  // Offers one word of notes, possibly after a few idle cycles, and waits for
  // it to be taken. Valid is left high so that back-to-back words need no
  // second assignment within one step. The expectation is queued on the edge
  // that accepts the word.
  task automatic push_notes(input logic [11:0] ps, input logic [7:0] ln,
                            input logic typed, input chord_res_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      notes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    notes_ch.valid       <= 1'b1;
    notes_ch.pitch_set   <= ps;
    notes_ch.lowest_note <= ln;
    @(posedge clk);
    while (!notes_ch.ready) @(posedge clk);
    pending_chords.insert(pending_chords.size(), typed ? want : name_chord(ps, ln, cur_thr));
  endtask

  // Stops offering words and waits until every owed chord word has come out.
  task automatic drain_chords();
    notes_ch.valid <= 1'b0;
    while (pending_chords.size() != 0) @(posedge clk);
  endtask

  // Rewrites the accept threshold once the block has nothing in flight.
  task automatic set_threshold(input logic [18:0] thr);
    drain_chords();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_thr = thr;
  endtask

  // Random pitch set. Most are templates rotated to a random root, some with
  // one class flipped; the rest are empty, single notes, or pure noise.
  function automatic logic [11:0] pick_pitch_set();
    int           sel, root;
    chord_shape_t sh;
    logic [23:0]  wide;
    logic [11:0]  ps;
    sel = $urandom_range(99);
    if (sel < 5) return 12'h000;
    if (sel < 15) return 12'h001 << $urandom_range(11);
    if (sel < 30) return 12'($urandom);
    root = $urandom_range(11);
    sh = interval_template($urandom_range(48));
    wide = {12'h000, sh.iv} << root;
    ps = wide[11:0] | wide[23:12];
    if ($urandom_range(99) < 30) ps[$urandom_range(11)] ^= 1'b1;
    return ps;
  endfunction

  // Random lowest note: mostly a note whose class is in the set, sometimes any
  // note, sometimes an unknown (negative) value.
  function automatic logic [7:0] pick_lowest(input logic [11:0] ps);
    int sel, k, pc;
    sel = $urandom_range(99);
    if (sel < 25) return 8'(256 - $urandom_range(128, 1));
    if (sel < 85 && ps != 12'h000) begin
      k = $urandom_range($countones(ps) - 1);
      pc = 0;
      for (int i = 0; i < 12; i++) begin
        if (ps[i]) begin
          if (k == 0) pc = i;
          k--;
        end
      end
      return 8'(pc + 12 * $urandom_range((127 - pc) / 12));
    end
    return 8'($urandom_range(127));
  endfunction

  // Directed words. Lowest notes 8'hFF, 8'hFE and 8'h80 are unknown values.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Empty set, with and without a lowest note: every field is zero.
    '{ps: 12'h000, ln: 8'd60, set_thr: 1'b0, thr: 19'd0, typed: 1'b1, want: NONE},
    '{ps: 12'h000, ln: 8'hFF, set_thr: 1'b0, thr: 19'd0, typed: 1'b1, want: NONE},
    // Single note named by a lowest note whose class is not in the set.
    '{ps: 12'h001, ln: 8'd61, set_thr: 1'b0, thr: 19'd0, typed: 1'b1,
      want: '{status: ctm_pkg::ST_SINGLE, root: 4'd1, bass: 4'd1, idx: 6'd0,
              score: ctm_pkg::FULL_SCALE, inv: 1'b0, flats: 1'b1}},
    // Single note without a lowest note: the one class in the set.
    '{ps: 12'h800, ln: 8'hFF, set_thr: 1'b0, thr: 19'd0, typed: 1'b1,
      want: '{status: ctm_pkg::ST_SINGLE, root: 4'd11, bass: 4'd11, idx: 6'd0,
              score: ctm_pkg::FULL_SCALE, inv: 1'b0, flats: 1'b0}},
    // Highest note number, 127, is class 7.
    '{ps: 12'h004, ln: 8'd127, set_thr: 1'b0, thr: 19'd0, typed: 1'b1,
      want: '{status: ctm_pkg::ST_SINGLE, root: 4'd7, bass: 4'd7, idx: 6'd0,
              score: ctm_pkg::FULL_SCALE, inv: 1'b0, flats: 1'b0}},
    '{ps: 12'h400, ln: 8'd0, set_thr: 1'b0, thr: 19'd0, typed: 1'b1,
      want: '{status: ctm_pkg::ST_SINGLE, root: 4'd0, bass: 4'd0, idx: 6'd0,
              score: ctm_pkg::FULL_SCALE, inv: 1'b0, flats: 1'b0}},
    // An exact C major triad fits the first template at full scale.
    '{ps: 12'h091, ln: 8'd60, set_thr: 1'b0, thr: 19'd0, typed: 1'b1,
      want: '{status: ctm_pkg::ST_CHORD, root: 4'd0, bass: 4'd0, idx: 6'd0,
              score: ctm_pkg::FULL_SCALE, inv: 1'b0, flats: 1'b0}},
    // Inversion, bass outside the set, and an unknown note other than -1.
    '{ps: 12'h091, ln: 8'd64, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    '{ps: 12'h091, ln: 8'd62, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    '{ps: 12'h091, ln: 8'h80, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    '{ps: 12'h089, ln: 8'hFF, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    // All twelve classes, a tritone and a semitone cluster.
    '{ps: 12'hFFF, ln: 8'd127, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    '{ps: 12'h041, ln: 8'd0, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    '{ps: 12'h003, ln: 8'hFE, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    // Seventh chord, full major scale, diminished seventh, augmented triad.
    '{ps: 12'h491, ln: 8'd70, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    '{ps: 12'hAB5, ln: 8'd65, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    '{ps: 12'h249, ln: 8'd63, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    '{ps: 12'h111, ln: 8'd68, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    // A threshold above full scale makes every chord unknown, not single notes.
    '{ps: 12'h091, ln: 8'd60, set_thr: 1'b1, thr: 19'h7FFFF, typed: 1'b1,
      want: '{status: ctm_pkg::ST_UNKNOWN, root: 4'd0, bass: 4'd0, idx: 6'd0,
              score: 19'd0, inv: 1'b0, flats: 1'b0}},
    '{ps: 12'h001, ln: 8'hFF, set_thr: 1'b0, thr: 19'd0, typed: 1'b1,
      want: '{status: ctm_pkg::ST_SINGLE, root: 4'd0, bass: 4'd0, idx: 6'd0,
              score: ctm_pkg::FULL_SCALE, inv: 1'b0, flats: 1'b0}},
    // A score equal to the threshold is still accepted.
    '{ps: 12'h091, ln: 8'd60, set_thr: 1'b1, thr: ctm_pkg::FULL_SCALE, typed: 1'b1,
      want: '{status: ctm_pkg::ST_CHORD, root: 4'd0, bass: 4'd0, idx: 6'd0,
              score: ctm_pkg::FULL_SCALE, inv: 1'b0, flats: 1'b0}},
    '{ps: 12'h6AD, ln: 8'd45, set_thr: 1'b1, thr: 19'd0, typed: 1'b0, want: NONE},
    '{ps: 12'h801, ln: 8'd127, set_thr: 1'b0, thr: 19'd0, typed: 1'b0, want: NONE},
    '{ps: 12'h081, ln: 8'd55, set_thr: 1'b1, thr: ctm_pkg::THRESH_RESET, typed: 1'b0,
      want: NONE}
  };

  // Chord sink. The word is sampled on the edge where valid and ready are
  // both high; ready for the next cycle is then chosen at random, or held low
  // while a hold-off is running.
  initial begin : chord_sink
    chord_res_t got;
    chord_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && chord_ch.valid && chord_ch.ready) begin
        got = '{status: ctm_pkg::status_t'(chord_ch.status), root: chord_ch.root_class,
                bass: chord_ch.bass_class, idx: chord_ch.chord_index,
                score: chord_ch.match_score, inv: chord_ch.is_inversion,
                flats: chord_ch.use_flats};
        compare_chord(got);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        chord_ch.ready <= 1'b0;
      end else begin
        chord_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Main sequence: reset, directed table, random phases, then the verdict.
  initial begin : notes_source
    stim_row_t   row;
    logic [11:0] ps;
    logic [7:0]  ln;
    logic [18:0] phase_thr [PHASES];
    int          phase_len [PHASES];
    int          phase_mode [PHASES];

    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    notes_ch.valid       <= 1'b0;
    notes_ch.pitch_set   <= '0;
    notes_ch.lowest_note <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The table starts at the reset threshold and rewrites it where a row asks.
    src_idle_pct = 24;
    snk_idle_pct = 56;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.set_thr) set_threshold(row.thr);
      push_notes(row.ps, row.ln, row.typed, row.want);
    end

    // Random phases: threshold at zero, at full scale, above full scale, then
    // three random settings. The idle pattern moves from the sender-light
    // pattern to the reverse and finally to no idling at all.
    phase_thr  = '{19'd0, ctm_pkg::FULL_SCALE, 19'h7FFFF,
                   19'($urandom_range(300000, 60000)),
                   19'($urandom_range(250000, 100000)), 19'($urandom_range(420000, 0))};
    phase_len  = '{160, 60, 40, 220, 220, 200};
    phase_mode = '{0, 0, 1, 1, 2, 2};
    for (int p = 0; p < PHASES; p++) begin
      set_threshold(phase_thr[p]);
      case (phase_mode[p])
        0: begin
          src_idle_pct = 24;
          snk_idle_pct = 56;
        end
        1: begin
          src_idle_pct = 56;
          snk_idle_pct = 24;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      // A long hold-off on the chord side fills the block so that it must
      // stall the notes side while words keep being offered.
      if (p == 3) sink_hold = 6000;
      for (int i = 0; i < phase_len[p]; i++) begin
        // Halfway through one phase the sender pauses until the block is empty.
        if (p == 4 && i == phase_len[p] / 2) drain_chords();
        ps = pick_pitch_set();
        ln = pick_lowest(ps);
        push_notes(ps, ln, 1'b0, NONE);
      end
    end

    drain_chords();
    // Any word that shows up late counts as unexpected during this tail.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_chords.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin : watchdog
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
